[rtl/core/rstok_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstok_pkg
// Shared types and constants for the RESP stream tokenizer: parse modes,
// token kind codes, protocol characters and default widths.
// ----------------------------------------------------------------------------
package rstok_pkg;

	// default width of the bulk length accumulator
	localparam int unsigned LEN_WIDTH_DEF = 32;

	// fixed widths of the counters and the configuration register
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned CFG_W   = 32;

	// reset value of the largest accepted bulk length
	localparam logic [CFG_W-1:0] MAX_BULK_RESET = 32'h2000_0000;

	// parse modes
	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_LINE    = 3'd1,
		M_LINE_CR = 3'd2,
		M_LEN     = 3'd3,
		M_LEN_CR  = 3'd4,
		M_BULK    = 3'd5,
		M_FAULT   = 3'd6
	} mode_t;

	// token kind codes
	localparam logic [2:0] K_SIMPLE    = 3'd0;
	localparam logic [2:0] K_ERROR     = 3'd1;
	localparam logic [2:0] K_INTEGER   = 3'd2;
	localparam logic [2:0] K_BULK      = 3'd3;
	localparam logic [2:0] K_ARRAY     = 3'd4;
	localparam logic [2:0] K_MALFORMED = 3'd5;

	// protocol characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// decimal digit test
	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

[rtl/core/rstok_dec_acc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstok_dec_acc
// Saturating decimal accumulate step: value * 10 + digit, clamped to all ones
// when the result does not fit in WIDTH bits.
// ----------------------------------------------------------------------------
module rstok_dec_acc #(
	parameter int unsigned WIDTH = 32
) (
	input  logic [WIDTH-1:0] value,
	input  logic [3:0]       digit,
	output logic [WIDTH-1:0] result
);
	logic [WIDTH+3:0] sum;

	// times ten as two shifted adds, plus the digit
	assign sum = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {{WIDTH{1'b0}}, digit};

	// clamp on overflow
	assign result = (sum[WIDTH+3:WIDTH] != 4'd0) ? {WIDTH{1'b1}} : sum[WIDTH-1:0];

endmodule

[rtl/core/resp_stream_tokenizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_stream_tokenizer_core
// Byte-serial RESP2 tokenizer: tags payload bytes with their token kind and
// checks the array count at message end.
// ----------------------------------------------------------------------------
// The block takes one message byte per clock and returns at most one word per
// byte, in the cycle after the byte is accepted. The whole per-byte parser update
// (mode, hold byte, decimal accumulate, counters) sits between the input
// handshake and a single result register, so the sustained rate is one byte
// per cycle whenever the result side is not stalling; in_stall is high only
// while a result word waits and out_stall is high. Lines opened by '+', '-',
// ':' and '*' are delivered byte by byte without the CR LF, a '$' length line
// is consumed and its payload bytes follow as bulk, and the word for the byte
// marked in_last carries message_end and count_ok. max_bulk_length should be
// written only while no message is in flight. There is no clearing pass.
// ----------------------------------------------------------------------------
module resp_stream_tokenizer_core #(
	parameter int unsigned LEN_WIDTH = rstok_pkg::LEN_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rstok_pkg::CFG_W-1:0] cfg_data,
	// input bytes
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	// result words
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                token_kind,
	output logic [7:0]                out_byte,
	output logic                      byte_valid,
	output logic                      token_first,
	output logic                      token_last,
	output logic                      message_end,
	output logic                      count_ok
);
	import rstok_pkg::*;

	localparam int unsigned CMP_W = (LEN_WIDTH > CFG_W) ? LEN_WIDTH : CFG_W;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// parser state
	mode_t              mode_q, mode_d;
	logic [2:0]         kind_q, kind_d;
	logic [LEN_WIDTH-1:0] len_q, len_d;
	logic [LEN_WIDTH-1:0] rem_q, rem_d;
	logic [COUNT_W-1:0] arr_q, arr_d;
	logic               hah_q, hah_d;
	logic [COUNT_W-1:0] tc_q, tc_d;
	logic               fp_q, fp_d;
	logic [7:0]         hold_q, hold_d;
	logic               hv_q, hv_d;
	logic               dg_q, dg_d;
	logic               lf_q, lf_d;
	logic               hc_q, hc_d;
	logic [CFG_W-1:0]   max_bulk_q;

	// result register
	logic               out_valid_q;
	logic [2:0]         kind_s1;
	logic [7:0]         byte_s1;
	logic               bvalid_s1, first_s1, last_s1, mend_s1, cok_s1;

	// event of the current byte
	logic               have;
	logic [2:0]         ev_kind;
	logic [7:0]         ev_byte;
	logic               ev_valid, ev_first, ev_last, ev_cok;

	logic               in_acc;
	logic               b_digit, lead_minus, acc_en;
	logic [LEN_WIDTH-1:0] len_sat;
	logic [COUNT_W-1:0] arr_sat;
	logic [LEN_WIDTH-1:0] rem_dec;
	logic               open_tok;
	logic [2:0]         mark_kind;
	logic               mark_hit;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_acc    = in_valid & ~in_stall;

	// decimal accumulate steps
	rstok_dec_acc #(.WIDTH(LEN_WIDTH)) u_len_acc (
		.value  (len_q),
		.digit  (in_byte[3:0]),
		.result (len_sat)
	);

	rstok_dec_acc #(.WIDTH(COUNT_W)) u_arr_acc (
		.value  (arr_q),
		.digit  (in_byte[3:0]),
		.result (arr_sat)
	);

	// classify the byte for the digit run
	assign b_digit    = is_digit(in_byte);
	assign lead_minus = lf_q && (kind_q == K_BULK) && (in_byte == CH_MINUS);
	assign acc_en     = !lead_minus && dg_q && b_digit;
	assign rem_dec    = rem_q - {{(LEN_WIDTH-1){1'b0}}, 1'b1};

	// decode a token marker
	always_comb begin
		mark_hit  = 1'b1;
		mark_kind = K_SIMPLE;
		unique case (in_byte)
			CH_PLUS:   mark_kind = K_SIMPLE;
			CH_MINUS:  mark_kind = K_ERROR;
			CH_COLON:  mark_kind = K_INTEGER;
			CH_DOLLAR: mark_kind = K_BULK;
			CH_STAR:   mark_kind = K_ARRAY;
			default:   mark_hit  = 1'b0;
		endcase
	end

	// next state and event for one byte
	always_comb begin
		mode_d = mode_q;
		kind_d = kind_q;
		len_d  = len_q;
		rem_d  = rem_q;
		arr_d  = arr_q;
		hah_d  = hah_q;
		tc_d   = tc_q;
		fp_d   = fp_q;
		hold_d = hold_q;
		hv_d   = hv_q;
		dg_d   = dg_q;
		lf_d   = lf_q;
		hc_d   = hc_q;

		have     = 1'b0;
		ev_kind  = K_SIMPLE;
		ev_byte  = 8'd0;
		ev_valid = 1'b0;
		ev_first = 1'b0;
		ev_last  = 1'b0;
		ev_cok   = 1'b0;
		open_tok = 1'b0;

		unique case (mode_q)
			M_IDLE: begin
				if (mark_hit) begin
					kind_d = mark_kind;
					fp_d   = 1'b1;
					hv_d   = 1'b0;
					lf_d   = 1'b1;
					dg_d   = 1'b1;
					len_d  = '0;
					hc_d   = (mark_kind == K_ARRAY) && (tc_q == '0);
					mode_d = (mark_kind == K_BULK) ? M_LEN : M_LINE;
				end
			end
			M_LINE: begin
				if (in_byte == CH_CR) begin
					if (hv_q) begin
						have     = 1'b1;
						ev_kind  = kind_q;
						ev_byte  = hold_q;
						ev_valid = 1'b1;
						ev_first = fp_q;
						fp_d     = 1'b0;
						hv_d     = 1'b0;
					end
					mode_d = M_LINE_CR;
				end else begin
					// digit run on this byte
					lf_d  = 1'b0;
					hah_d = hah_q | (lf_q & hc_q & b_digit);
					dg_d  = acc_en;
					if (acc_en && kind_q == K_BULK)
						len_d = len_sat;
					else if (acc_en && kind_q == K_ARRAY && hc_q)
						arr_d = arr_sat;
					have     = 1'b1;
					ev_kind  = kind_q;
					ev_valid = 1'b1;
					ev_first = fp_q;
					fp_d     = 1'b0;
					if (hv_q) begin
						ev_byte = hold_q;
						hold_d  = in_byte;
					end else begin
						ev_byte = in_byte;
					end
				end
			end
			M_LINE_CR: begin
				have     = 1'b1;
				ev_kind  = kind_q;
				ev_first = fp_q;
				fp_d     = 1'b0;
				if (in_byte == CH_LF) begin
					ev_last = 1'b1;
					if (tc_q != COUNT_MAX)
						tc_d = tc_q + COUNT_W'(1);
					mode_d = M_IDLE;
				end else begin
					// lone CR is payload; it ends the digit run
					lf_d     = 1'b0;
					dg_d     = 1'b0;
					ev_byte  = CH_CR;
					ev_valid = 1'b1;
					if (in_byte != CH_CR) begin
						hold_d = in_byte;
						hv_d   = 1'b1;
						mode_d = M_LINE;
					end
				end
			end
			M_LEN: begin
				if (in_byte == CH_CR) begin
					mode_d = M_LEN_CR;
				end else begin
					lf_d  = 1'b0;
					hah_d = hah_q | (lf_q & hc_q & b_digit);
					dg_d  = acc_en;
					if (acc_en && kind_q == K_BULK)
						len_d = len_sat;
					else if (acc_en && kind_q == K_ARRAY && hc_q)
						arr_d = arr_sat;
				end
			end
			M_LEN_CR: begin
				if (in_byte == CH_LF) begin
					if (CMP_W'(len_q) > CMP_W'(max_bulk_q)) begin
						have     = 1'b1;
						ev_kind  = K_MALFORMED;
						ev_first = 1'b1;
						ev_last  = 1'b1;
						fp_d     = 1'b0;
						mode_d   = M_FAULT;
					end else if (len_q == '0) begin
						have     = 1'b1;
						ev_kind  = K_BULK;
						ev_first = fp_q;
						ev_last  = 1'b1;
						fp_d     = 1'b0;
						if (tc_q != COUNT_MAX)
							tc_d = tc_q + COUNT_W'(1);
						mode_d = M_IDLE;
					end else begin
						rem_d  = len_q;
						mode_d = M_BULK;
					end
				end else begin
					lf_d = 1'b0;
					dg_d = 1'b0;
					if (in_byte != CH_CR)
						mode_d = M_LEN;
				end
			end
			M_BULK: begin
				rem_d    = rem_dec;
				have     = 1'b1;
				ev_kind  = K_BULK;
				ev_byte  = in_byte;
				ev_valid = 1'b1;
				ev_first = fp_q;
				ev_last  = (rem_dec == '0);
				fp_d     = 1'b0;
				if (rem_dec == '0) begin
					if (tc_q != COUNT_MAX)
						tc_d = tc_q + COUNT_W'(1);
					mode_d = M_IDLE;
				end
			end
			default: begin
			end
		endcase

		// close the message on the last byte
		if (in_last) begin
			open_tok = (mode_d == M_LINE) || (mode_d == M_LINE_CR) || (mode_d == M_LEN) ||
				(mode_d == M_LEN_CR) || (mode_d == M_BULK);
			if (open_tok) begin
				ev_kind  = K_MALFORMED;
				ev_byte  = 8'd0;
				ev_valid = 1'b0;
				ev_first = 1'b1;
				ev_last  = 1'b1;
				ev_cok   = 1'b0;
			end else if (mode_d == M_FAULT || tc_d == '0) begin
				ev_cok = 1'b0;
			end else if (hah_d) begin
				ev_cok = ((tc_d - COUNT_W'(1)) == arr_d);
			end else begin
				ev_cok = 1'b1;
			end
			have   = 1'b1;
			mode_d = M_IDLE;
			kind_d = K_SIMPLE;
			len_d  = '0;
			rem_d  = '0;
			arr_d  = '0;
			hah_d  = 1'b0;
			tc_d   = '0;
			fp_d   = 1'b0;
			hv_d   = 1'b0;
			dg_d   = 1'b0;
			lf_d   = 1'b0;
			hc_d   = 1'b0;
		end
	end

	// state registers; parser state advances only on an accepted byte, max bulk on cfg_valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_IDLE;
			kind_q     <= K_SIMPLE;
			len_q      <= '0;
			rem_q      <= '0;
			arr_q      <= '0;
			hah_q      <= 1'b0;
			tc_q       <= '0;
			fp_q       <= 1'b0;
			hv_q       <= 1'b0;
			dg_q       <= 1'b0;
			lf_q       <= 1'b0;
			hc_q       <= 1'b0;
			max_bulk_q <= MAX_BULK_RESET;
		end else begin
			if (in_acc) begin
				mode_q <= mode_d;
				kind_q <= kind_d;
				len_q  <= len_d;
				rem_q  <= rem_d;
				arr_q  <= arr_d;
				hah_q  <= hah_d;
				tc_q   <= tc_d;
				fp_q   <= fp_d;
				hv_q   <= hv_d;
				dg_q   <= dg_d;
				lf_q   <= lf_d;
				hc_q   <= hc_d;
			end
			if (cfg_valid)
				max_bulk_q <= cfg_data;
		end
	end

	// hold byte is payload
	always_ff @(posedge clk) begin
		if (in_acc)
			hold_q <= hold_d;
	end

	// result word valid: load on an event, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= have;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (in_acc && have) begin
			kind_s1   <= ev_kind;
			byte_s1   <= ev_byte;
			bvalid_s1 <= ev_valid;
			first_s1  <= ev_first;
			last_s1   <= ev_last;
			mend_s1   <= in_last;
			cok_s1    <= ev_cok;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_kind  = kind_s1;
	assign out_byte    = byte_s1;
	assign byte_valid  = bvalid_s1;
	assign token_first = first_s1;
	assign token_last  = last_s1;
	assign message_end = mend_s1;
	assign count_ok    = cok_s1;

endmodule
